@@ hw/rtl/ait_pkg.sv @@
// ----------------------------------------------------------------------------
// ait_pkg
// Shared types and constants for the archive index table.
// ----------------------------------------------------------------------------
`default_nettype none
package ait_pkg;
    localparam logic [7:0] MAGIC_HI = 8'h42;
    localparam logic [7:0] MAGIC_LO = 8'h41;
    localparam int RECORD_BYTES = 80;
    localparam int MIN_STREAM = 8;
    localparam int HEADER_BYTES = 4;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_MAGIC = 3'd2;
    localparam logic [2:0] ST_TRUNC = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    localparam logic OP_STREAM = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // word queued from front to back
    typedef struct packed {
        logic        is_lookup;
        logic        commit;
        logic        clear;
        logic        report;
        logic [2:0]  status;
        logic [31:0] id;
        logic [31:0] offset;
        logic [31:0] packed_sz;
        logic [31:0] plain_sz;
        logic [7:0]  codec;
        logic [31:0] alen;
    } cmd_t;
endpackage
`default_nettype wire

@@ hw/rtl/ait_front.sv @@
// ----------------------------------------------------------------------------
// ait_front
// Stream parser: header, magic check, record staging and final status.
// Table fill level is tracked here so overflow status is known up front.
// ----------------------------------------------------------------------------
`default_nettype none
module ait_front #(
    parameter int MAX_ENTRIES = 64,
    parameter int CW = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic         s_opcode,
    input  wire logic [7:0]   s_data_byte,
    input  wire logic         s_last_byte,
    input  wire logic [31:0]  s_lookup_id,
    input  wire logic [31:0]  s_archive_length,
    output logic              q_valid,
    input  wire logic         q_ready,
    output ait_pkg::cmd_t     q_cmd
);
    logic [3:0]  hdr_reg;
    logic [15:0] decl_reg;
    logic [15:0] done_reg;
    logic [6:0]  pos_reg;
    logic [63:0] st0_reg, st1_reg;
    logic [7:0]  st2_reg;
    logic        magic_bad_reg, full_reg;
    logic [CW-1:0] fill_reg;

    ait_pkg::cmd_t cmd;
    logic [3:0]  hdr_next;
    logic [15:0] decl_next, done_next;
    logic [6:0]  pos_next;
    logic [63:0] st0_next, st1_next;
    logic [7:0]  st2_next;
    logic        bad_next, full_next;
    logic [CW-1:0] fill_next;
    logic        take;

    assign s_ready = !q_valid || q_ready;
    assign take = s_valid && s_ready;

    always_comb begin
        cmd = '0;
        cmd.is_lookup = (s_opcode == ait_pkg::OP_LOOKUP);
        cmd.id = s_lookup_id;
        cmd.alen = s_archive_length;
        hdr_next = hdr_reg; decl_next = decl_reg; done_next = done_reg;
        pos_next = pos_reg; st0_next = st0_reg; st1_next = st1_reg;
        st2_next = st2_reg; bad_next = magic_bad_reg; full_next = full_reg;
        fill_next = fill_reg;
        if (s_opcode == ait_pkg::OP_STREAM) begin
            if (hdr_reg < 4'(ait_pkg::MIN_STREAM)) hdr_next = hdr_reg + 4'd1;
            if (!magic_bad_reg) begin
                if (hdr_reg == 4'd0 && s_data_byte != ait_pkg::MAGIC_HI) begin
                    bad_next = 1'b1;
                end else if (hdr_reg == 4'd1 && s_data_byte != ait_pkg::MAGIC_LO) begin
                    bad_next = 1'b1;
                end else if (hdr_reg == 4'd2 || hdr_reg == 4'd3) begin
                    decl_next = {decl_reg[7:0], s_data_byte};
                end else begin
                    if (hdr_reg == 4'(ait_pkg::MIN_STREAM - 1)) begin
                        cmd.clear = 1'b1;
                        fill_next = '0;
                    end
                    if (hdr_reg >= 4'(ait_pkg::HEADER_BYTES) && done_reg < decl_reg) begin
                        if (pos_reg < 7'd8) st0_next = {st0_reg[55:0], s_data_byte};
                        else if (pos_reg < 7'd16) st1_next = {st1_reg[55:0], s_data_byte};
                        else if (pos_reg == 7'd16) st2_next = s_data_byte;
                        if (pos_reg == 7'(ait_pkg::RECORD_BYTES - 1)) begin
                            pos_next = '0;
                            done_next = done_reg + 16'd1;
                            if (fill_next < CW'(MAX_ENTRIES)) begin
                                cmd.commit = 1'b1;
                                fill_next = fill_next + CW'(1);
                            end else begin
                                full_next = 1'b1;
                            end
                        end else begin
                            pos_next = pos_reg + 7'd1;
                        end
                    end
                end
            end
            cmd.id = st0_next[63:32];
            cmd.offset = st0_next[31:0];
            cmd.packed_sz = st1_next[63:32];
            cmd.plain_sz = st1_next[31:0];
            cmd.codec = st2_next;
            if (s_last_byte) begin
                cmd.report = 1'b1;
                if (hdr_next < 4'(ait_pkg::MIN_STREAM)) cmd.status = ait_pkg::ST_SHORT;
                else if (bad_next) cmd.status = ait_pkg::ST_MAGIC;
                else if (done_next < decl_next) cmd.status = ait_pkg::ST_TRUNC;
                else if (full_next) cmd.status = ait_pkg::ST_FULL;
                else cmd.status = ait_pkg::ST_OK;
                hdr_next = '0; decl_next = '0; done_next = '0; pos_next = '0;
                st0_next = '0; st1_next = '0; st2_next = '0;
                bad_next = 1'b0; full_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid <= 1'b0;
            hdr_reg <= '0; decl_reg <= '0; done_reg <= '0; pos_reg <= '0;
            st0_reg <= '0; st1_reg <= '0; st2_reg <= '0;
            magic_bad_reg <= 1'b0; full_reg <= 1'b0; fill_reg <= '0;
        end else begin
            if (take) begin
                q_valid <= 1'b1;
                q_cmd <= cmd;
                hdr_reg <= hdr_next; decl_reg <= decl_next; done_reg <= done_next;
                pos_reg <= pos_next; st0_reg <= st0_next; st1_reg <= st1_next;
                st2_reg <= st2_next; magic_bad_reg <= bad_next;
                full_reg <= full_next; fill_reg <= fill_next;
            end else if (q_ready) begin
                q_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/ait_back.sv @@
// ----------------------------------------------------------------------------
// ait_back
// Entry table: commits records and runs the sequential first-match search.
// ----------------------------------------------------------------------------
`default_nettype none
module ait_back #(
    parameter int MAX_ENTRIES = 64,
    parameter int CW = $clog2(MAX_ENTRIES + 1),
    parameter int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         q_valid,
    output logic              q_ready,
    input  wire ait_pkg::cmd_t q_cmd,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic              m_result_kind,
    output logic [2:0]        m_parse_status,
    output logic              m_found,
    output logic [31:0]       m_data_offset,
    output logic [31:0]       m_packed_size,
    output logic [31:0]       m_plain_size,
    output logic [7:0]        m_codec,
    output logic              m_in_bounds
);
    typedef enum logic [1:0] {IDLE, READ, CHECK} state_t;
    localparam int EW = 136;

    logic [EW-1:0] mem [MAX_ENTRIES];
    logic [EW-1:0] rd_reg;
    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [31:0] want_reg;
    logic [32:0] alen_reg;
    logic [32:0] sum;
    logic        hit, at_end, m_set;

    assign sum = {1'b0, rd_reg[103:72]} + {1'b0, rd_reg[71:40]};
    assign q_ready = (state_reg == IDLE) && (!m_valid || m_ready);
    assign hit = (rd_reg[135:104] == want_reg);
    assign at_end = (idx_reg + CW'(1) == count_reg);
    assign m_set = (state_reg == IDLE)
                 ? (q_valid && q_ready
                    && (q_cmd.is_lookup ? (count_reg == '0) : q_cmd.report))
                 : ((state_reg == CHECK) && (hit || at_end));

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready && !q_cmd.is_lookup && q_cmd.commit)
            mem[(q_cmd.clear ? AW'(0) : count_reg[AW-1:0])] <=
                {q_cmd.id, q_cmd.offset, q_cmd.packed_sz, q_cmd.plain_sz, q_cmd.codec};
        rd_reg <= mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            m_valid <= 1'b0;
            count_reg <= '0;
            idx_reg <= '0;
        end else begin
            if (m_set) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            case (state_reg)
                IDLE: begin
                    if (q_valid && q_ready) begin
                        if (q_cmd.is_lookup) begin
                            want_reg <= q_cmd.id;
                            alen_reg <= {1'b0, q_cmd.alen};
                            idx_reg <= '0;
                            if (count_reg == '0) begin
                                m_result_kind <= 1'b1;
                                m_parse_status <= ait_pkg::ST_OK;
                                m_found <= 1'b0; m_data_offset <= '0;
                                m_packed_size <= '0; m_plain_size <= '0;
                                m_codec <= '0; m_in_bounds <= 1'b0;
                            end else begin
                                state_reg <= READ;
                            end
                        end else begin
                            if (q_cmd.clear) count_reg <= q_cmd.commit ? CW'(1) : '0;
                            else if (q_cmd.commit) count_reg <= count_reg + CW'(1);
                            if (q_cmd.report) begin
                                m_result_kind <= 1'b0;
                                m_parse_status <= q_cmd.status;
                                m_found <= 1'b0; m_data_offset <= '0;
                                m_packed_size <= '0; m_plain_size <= '0;
                                m_codec <= '0; m_in_bounds <= 1'b0;
                            end
                        end
                    end
                end
                READ: state_reg <= CHECK;
                CHECK: begin
                    if (hit || at_end) begin
                        m_result_kind <= 1'b1;
                        m_parse_status <= ait_pkg::ST_OK;
                        state_reg <= IDLE;
                        if (hit) begin
                            m_found <= 1'b1;
                            m_data_offset <= rd_reg[103:72];
                            m_packed_size <= rd_reg[71:40];
                            m_plain_size <= rd_reg[39:8];
                            m_codec <= rd_reg[7:0];
                            m_in_bounds <= (sum <= alen_reg);
                        end else begin
                            m_found <= 1'b0; m_data_offset <= '0;
                            m_packed_size <= '0; m_plain_size <= '0;
                            m_codec <= '0; m_in_bounds <= 1'b0;
                        end
                    end else begin
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= READ;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/archive_index_table.sv @@
// ----------------------------------------------------------------------------
// archive_index_table
// Streamed archive index parser with a first-match lookup table.
// ----------------------------------------------------------------------------
// Input channel s_*: one word per handshake, either an index stream byte
// (opcode 0) or a lookup request (opcode 1). Result channel m_*: a parse
// status after each byte marked last, and one answer per lookup.
// Stream bytes are taken one per cycle while no lookup search runs and the
// result channel is not held; the front parser registers one command word,
// the back end commits records and registers status answers on taking it.
// A lookup walks the held entries in order (registered memory read, then
// compare) to the first match; with none held it answers on acceptance.
// The front keeps accepting while the back end searches, up to one
// queued word. Reset clears the parser, the fill count and the handshakes;
// table contents are left as they are. A stalled receiver holds m_valid
// and the result, and backpressure reaches s_ready through the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module archive_index_table #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_opcode,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    input  wire logic [31:0] s_lookup_id,
    input  wire logic [31:0] s_archive_length,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_result_kind,
    output logic [2:0]       m_parse_status,
    output logic             m_found,
    output logic [31:0]      m_data_offset,
    output logic [31:0]      m_packed_size,
    output logic [31:0]      m_plain_size,
    output logic [7:0]       m_codec,
    output logic             m_in_bounds
);
    logic q_valid, q_ready;
    ait_pkg::cmd_t q_cmd;

    ait_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_opcode, .s_data_byte,
        .s_last_byte, .s_lookup_id, .s_archive_length,
        .q_valid, .q_ready, .q_cmd
    );

    ait_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .m_valid, .m_ready, .m_result_kind, .m_parse_status, .m_found,
        .m_data_offset, .m_packed_size, .m_plain_size, .m_codec, .m_in_bounds
    );
endmodule
`default_nettype wire

@@ sim/archive_index_table_test.sv @@
// ----------------------------------------------------------------------------
// archive_index_table_test
// Self-checking bench for the archive index parser and lookup table.
// ----------------------------------------------------------------------------
// Drives index streams (good, short, bad magic, truncated, with trailing
// bytes) and lookups through the valid/ready input channel. Each
// accepted word is run through a local predictor of the parser and table,
// and each result word is compared field by field with the oldest prediction
// (or the directed answer). Sender and receiver idle at random in several
// phases; one long receiver hold-off lets the block back up into its input.
// ----------------------------------------------------------------------------
`default_nettype none
module archive_index_table_test;

    localparam int TABLE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic        found;
        logic [31:0] offset;
        logic [31:0] packed_sz;
        logic [31:0] plain_sz;
        logic [7:0]  codec;
        logic        in_bounds;
    } answer_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  data;
        logic        last;
        logic [31:0] id;
        logic [31:0] alen;
        logic        check;
        answer_t     want;
    } row_t;

    logic aclk;
    logic aresetn;
    logic s_valid, s_ready, s_opcode, s_last_byte;
    logic [7:0] s_data_byte;
    logic [31:0] s_lookup_id, s_archive_length;
    logic m_valid, m_ready, m_result_kind, m_found, m_in_bounds;
    logic [2:0] m_parse_status;
    logic [31:0] m_data_offset, m_packed_size, m_plain_size;
    logic [7:0] m_codec;

    archive_index_table dut (.*);

    // predictor state
    logic [31:0] tbl_id [TABLE_DEPTH];
    logic [31:0] tbl_off [TABLE_DEPTH];
    logic [31:0] tbl_pk [TABLE_DEPTH];
    logic [31:0] tbl_pl [TABLE_DEPTH];
    logic [7:0]  tbl_codec [TABLE_DEPTH];
    int unsigned held;
    int unsigned hdr_seen, decl, recs, rec_pos;
    logic [63:0] stage0, stage1;
    logic [7:0]  stage_codec;
    logic [2:0]  strm_st;

    answer_t answers_due[$];
    answer_t direct_due[$];
    logic    direct_flag[$];
    int errors = 0;
    int cycles = 0;
    int results_seen = 0;
    int words_sent = 0;
    int send_idle = 0, recv_idle = 0;
    bit hold_off = 0;
    int known_ids[$];

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void clear_parser();
        hdr_seen = 0; decl = 0; recs = 0; rec_pos = 0;
        stage0 = 0; stage1 = 0; stage_codec = 0; strm_st = ait_pkg::ST_OK;
    endfunction

    function automatic void take_record_byte(logic [7:0] b);
        if (rec_pos < 8) stage0 = {stage0[55:0], b};
        else if (rec_pos < 16) stage1 = {stage1[55:0], b};
        else if (rec_pos == 16) stage_codec = b;
        if (rec_pos + 1 >= ait_pkg::RECORD_BYTES) begin
            rec_pos = 0;
            recs = (recs + 1) & 16'hffff;
            if (held < TABLE_DEPTH) begin
                tbl_id[held] = stage0[63:32];
                tbl_off[held] = stage0[31:0];
                tbl_pk[held] = stage1[63:32];
                tbl_pl[held] = stage1[31:0];
                tbl_codec[held] = stage_codec;
                held++;
            end else begin
                strm_st = ait_pkg::ST_FULL;
            end
        end else begin
            rec_pos++;
        end
    endfunction

    function automatic void take_stream_byte(logic [7:0] b);
        int unsigned idx;
        idx = hdr_seen;
        if (idx < ait_pkg::MIN_STREAM) hdr_seen = idx + 1;
        if (strm_st == ait_pkg::ST_MAGIC) return;
        if ((idx == 0 && b != ait_pkg::MAGIC_HI) || (idx == 1 && b != ait_pkg::MAGIC_LO)) begin
            strm_st = ait_pkg::ST_MAGIC;
            return;
        end
        if (idx == 2 || idx == 3) begin
            decl = ((decl << 8) | b) & 16'hffff;
            return;
        end
        if (idx == ait_pkg::MIN_STREAM - 1) held = 0;
        if (idx >= ait_pkg::HEADER_BYTES && recs < decl) take_record_byte(b);
    endfunction

    // returns 1 when the word produces a result
    function automatic bit predict_word(row_t r, output answer_t a);
        logic [32:0] span;
        a = '0;
        if (r.op == ait_pkg::OP_STREAM) begin
            take_stream_byte(r.data);
            if (!r.last) return 0;
            if (hdr_seen < ait_pkg::MIN_STREAM) a.status = ait_pkg::ST_SHORT;
            else if (strm_st == ait_pkg::ST_MAGIC) a.status = ait_pkg::ST_MAGIC;
            else if (recs < decl) a.status = ait_pkg::ST_TRUNC;
            else if (strm_st == ait_pkg::ST_FULL) a.status = ait_pkg::ST_FULL;
            else a.status = ait_pkg::ST_OK;
            clear_parser();
            return 1;
        end
        a.kind = 1;
        for (int i = 0; i < held; i++) begin
            if (tbl_id[i] == r.id) begin
                span = {1'b0, tbl_off[i]} + {1'b0, tbl_pk[i]};
                a.found = 1;
                a.offset = tbl_off[i];
                a.packed_sz = tbl_pk[i];
                a.plain_sz = tbl_pl[i];
                a.codec = tbl_codec[i];
                a.in_bounds = span <= {1'b0, r.alen};
                break;
            end
        end
        return 1;
    endfunction

    task automatic send_word(row_t r);
        answer_t a;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_opcode <= r.op;
        s_data_byte <= r.data;
        s_last_byte <= r.last;
        s_lookup_id <= r.id;
        s_archive_length <= r.alen;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        if (predict_word(r, a)) begin
            answers_due.insert(answers_due.size(), a);
            direct_flag.insert(direct_flag.size(), r.check);
            direct_due.insert(direct_due.size(), r.want);
        end
    endtask

    function automatic row_t byte_row(logic [7:0] b, logic last);
        row_t r;
        r = '0;
        r.op = ait_pkg::OP_STREAM; r.data = b; r.last = last;
        r.id = $urandom; r.alen = $urandom;
        return r;
    endfunction

    function automatic row_t lookup_row(logic [31:0] id, logic [31:0] alen);
        row_t r;
        r = '0;
        r.op = ait_pkg::OP_LOOKUP; r.id = id; r.alen = alen;
        r.data = 8'($urandom); r.last = 1'($urandom);
        return r;
    endfunction

    task automatic send_lookup();
        logic [31:0] id, alen;
        id = known_ids.size() > 0 && $urandom_range(3) != 0 ?
             known_ids[$urandom_range(known_ids.size() - 1)] : $urandom;
        case ($urandom_range(3))
            0: alen = '1;
            1: alen = 0;
            default: alen = $urandom;
        endcase
        send_word(lookup_row(id, alen));
    endtask

    // whole stream; cut < 0 means complete, extra adds trailing bytes
    task automatic send_stream(int n_recs, int declared, int cut, int extra,
                               bit bad_magic, bit dup_ids);
        logic [7:0] bytes[$];
        logic [31:0] id, off, pk, pl;
        int total;
        bytes.insert(bytes.size(),
                     bad_magic ? 8'($urandom_range(1) ? 8'h43 : $urandom) : ait_pkg::MAGIC_HI);
        bytes.insert(bytes.size(), ait_pkg::MAGIC_LO);
        bytes.insert(bytes.size(), declared[15:8]);
        bytes.insert(bytes.size(), declared[7:0]);
        for (int i = 0; i < n_recs; i++) begin
            id = dup_ids && $urandom_range(3) == 0 && known_ids.size() > 0 ?
                 known_ids[$urandom_range(known_ids.size() - 1)] : $urandom;
            if ($urandom_range(7) == 0) id = '1;
            off = $urandom;
            pk = $urandom_range(3) == 0 ? $urandom : $urandom_range(65535);
            if ($urandom_range(3) == 0) off = $urandom_range(65535);
            pl = $urandom;
            known_ids.insert(known_ids.size(), id);
            if (known_ids.size() > 200) void'(known_ids.pop_front());
            for (int k = 3; k >= 0; k--) bytes.insert(bytes.size(), id[8*k +: 8]);
            for (int k = 3; k >= 0; k--) bytes.insert(bytes.size(), off[8*k +: 8]);
            for (int k = 3; k >= 0; k--) bytes.insert(bytes.size(), pk[8*k +: 8]);
            for (int k = 3; k >= 0; k--) bytes.insert(bytes.size(), pl[8*k +: 8]);
            for (int k = 16; k < ait_pkg::RECORD_BYTES; k++)
                bytes.insert(bytes.size(), 8'($urandom));
        end
        for (int i = 0; i < extra; i++) bytes.insert(bytes.size(), 8'($urandom));
        total = cut >= 0 && cut < bytes.size() ? cut : bytes.size();
        if (total < 1) total = 1;
        for (int i = 0; i < total; i++) begin
            send_word(byte_row(bytes[i], i == total - 1));
            if ($urandom_range(60) == 0) send_lookup();
        end
    endtask

    // receiver
    initial begin
        m_ready = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off) m_ready <= 0;
            else m_ready <= $urandom_range(99) >= recv_idle;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        answer_t w, got;
        logic chk;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            got = '{m_result_kind, m_parse_status, m_found, m_data_offset,
                    m_packed_size, m_plain_size, m_codec, m_in_bounds};
            if (answers_due.size() == 0) begin
                $error("result word with none expected");
                errors++;
            end else begin
                w = answers_due.pop_front();
                chk = direct_flag.pop_front();
                if (chk) w = direct_due.pop_front();
                else void'(direct_due.pop_front());
                if (got.kind !== w.kind) begin
                    $error("result_kind exp %0d got %0d", w.kind, got.kind); errors++;
                end
                if (got.status !== w.status) begin
                    $error("parse_status exp %0d got %0d", w.status, got.status); errors++;
                end
                if (got.found !== w.found) begin
                    $error("found exp %0d got %0d", w.found, got.found); errors++;
                end
                if (got.offset !== w.offset) begin
                    $error("data_offset exp %h got %h", w.offset, got.offset); errors++;
                end
                if (got.packed_sz !== w.packed_sz) begin
                    $error("packed_size exp %h got %h", w.packed_sz, got.packed_sz);
                    errors++;
                end
                if (got.plain_sz !== w.plain_sz) begin
                    $error("plain_size exp %h got %h", w.plain_sz, got.plain_sz); errors++;
                end
                if (got.codec !== w.codec) begin
                    $error("codec exp %h got %h", w.codec, got.codec); errors++;
                end
                if (got.in_bounds !== w.in_bounds) begin
                    $error("in_bounds exp %0d got %0d", w.in_bounds, got.in_bounds);
                    errors++;
                end
            end
        end
    end

    row_t directed[$];

    function automatic row_t with_status(row_t r, logic [2:0] st);
        r.check = 1;
        r.want = '0;
        r.want.status = st;
        return r;
    endfunction

    initial begin
        int start_words;
        int pick;
        clear_parser();
        held = 0;
        aresetn = 0;
        s_valid = 0; s_opcode = 0; s_data_byte = 0; s_last_byte = 0;
        s_lookup_id = 0; s_archive_length = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed table
        directed.insert(directed.size(), lookup_row(32'h0, 32'hffffffff));
        directed[$].check = 1; directed[$].want = '0; directed[$].want.kind = 1;
        directed.insert(directed.size(), lookup_row(32'hffffffff, 32'h0));
        directed[$].check = 1; directed[$].want = '0; directed[$].want.kind = 1;
        directed.insert(directed.size(),
                        with_status(byte_row(ait_pkg::MAGIC_HI, 1), ait_pkg::ST_SHORT));
        directed.insert(directed.size(), byte_row(8'hff, 0));
        directed.insert(directed.size(), with_status(byte_row(8'h00, 1), ait_pkg::ST_SHORT));
        for (int i = 0; i < 7; i++)
            directed.insert(directed.size(), byte_row(i == 0 ? 8'h00 : 8'hff, 0));
        directed.insert(directed.size(), with_status(byte_row(8'h55, 1), ait_pkg::ST_MAGIC));
        directed.insert(directed.size(), byte_row(ait_pkg::MAGIC_HI, 0));
        directed.insert(directed.size(), byte_row(8'h40, 0));
        for (int i = 0; i < 5; i++) directed.insert(directed.size(), byte_row(8'h00, 0));
        directed.insert(directed.size(), with_status(byte_row(8'h00, 1), ait_pkg::ST_MAGIC));
        foreach (directed[i]) send_word(directed[i]);

        // empty table, extreme count, good two-record stream
        send_stream(0, 0, -1, 4, 0, 0);
        send_lookup();
        send_stream(0, 16'hffff, -1, 6, 0, 0);
        send_stream(2, 2, -1, 3, 0, 1);
        send_lookup(); send_lookup(); send_lookup();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0; recv_idle = 0; end
                1: begin send_idle = 51; recv_idle = 0; end
                2: begin send_idle = 0; recv_idle = 51; end
                default: begin send_idle = 19; recv_idle = 19; end
            endcase
            start_words = words_sent;
            if (ph == 2) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(posedge aclk);
                        hold_off = 0;
                    end
                    repeat (40) send_lookup();
                join
            end
            while (words_sent - start_words < 60) begin
                pick = $urandom_range(9);
                if (pick < 4) send_stream(0, 0, -1, $urandom_range(2, 6),
                                         $urandom_range(3) != 0, 1);
                else if (pick < 8) send_lookup();
                else if (pick == 8) send_stream(1, 2, $urandom_range(1, 12), 0, 0, 1);
                else send_stream(1, 1, $urandom_range(1, 20), 0, $urandom_range(1), 1);
            end
        end
        s_valid <= 0;
        recv_idle = 0;
        while (answers_due.size() > 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("Sent %0d words: streams ending ok, short, bad magic, truncated, with tails",
                 words_sent);
        $display("plus lookups, under four idling phases and one long hold-off; %0d results",
                 results_seen);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire
